[src/okc_pkg.sv]
// shared constants and types for the online k-means color clustering block
package okc_pkg;

	localparam int MAX_CLUSTERS = 16;
	localparam int IDX_W        = $clog2(MAX_CLUSTERS);
	localparam int NCL_W        = 5;
	localparam int COUNT_BITS   = 32;
	localparam int SUM_W        = 40;
	localparam int MEAN_W       = 16;
	localparam int DIST_W       = 2 * MEAN_W + 2;
	localparam int DVD_W        = SUM_W + 8;
	localparam int DIV_STEPS    = DVD_W;
	localparam int DCNT_W       = $clog2(DIV_STEPS);
	localparam int NCL_RESET    = 6;

	localparam logic OP_PIXEL = 1'b0;
	localparam logic OP_SEED  = 1'b1;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_RD,
		S_UPD,
		S_DIV,
		S_WR,
		S_EMIT
	} okc_state_t;

	typedef logic [2:0][MEAN_W-1:0] okc_means_t;
	typedef logic [2:0][SUM_W-1:0]  okc_sums_t;

endpackage

[src/online_kmeans_color_clustering.sv]
// online k-means color clustering over an rgb pixel stream
// A seed beat loads one cluster. For a pixel beat, the distance scan
// reads one mean per cycle for each active cluster from the mean memory
// through a three-stage read/square/compare pipeline, then the chosen
// cluster is read back and, unless its count is saturated, its sums and
// count are updated and three bit-serial dividers run 48 steps, one
// quotient bit per cycle, to form the new mean.
// One item is in work at a time; a finished result waits in the output
// register while the next item is taken. Cluster state is undefined until
// a cluster is seeded.
module online_kmeans_color_clustering (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [okc_pkg::NCL_W-1:0]  cfg_data,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic                       opcode,
	input  logic [3:0]                 cluster_index,
	input  logic [7:0]                 red,
	input  logic [7:0]                 green,
	input  logic [7:0]                 blue,
	input  logic                       end_of_pass,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic [3:0]                 label,
	output logic [15:0]                mean_red,
	output logic [15:0]                mean_green,
	output logic [15:0]                mean_blue,
	output logic                       pass_done
);
	import okc_pkg::*;

	okc_state_t state_q, state_nxt;

	logic [NCL_W-1:0]        ncl_q;
	logic [NCL_W-1:0]        act_last;
	logic [2:0][7:0]         pix_q;
	logic                    eop_q;

	okc_means_t              means_mem [MAX_CLUSTERS];
	okc_sums_t               sums_mem  [MAX_CLUSTERS];
	logic [COUNT_BITS-1:0]   cnt_mem   [MAX_CLUSTERS];

	logic                    rd_en;
	logic [IDX_W-1:0]        rd_addr;
	okc_means_t              means_rd_s1;
	okc_sums_t               sums_rd_s1;
	logic [COUNT_BITS-1:0]   cnt_rd_s1;

	logic [NCL_W-1:0]        issue_q;
	logic                    issue_active;
	logic                    v_s1, v_s2;
	logic [IDX_W-1:0]        idx_s1, idx_s2;
	logic [2:0][2*MEAN_W-1:0] sq_s2;
	logic [DIST_W-1:0]       dist_sum;
	logic [DIST_W-1:0]       best_d_q;
	logic [IDX_W-1:0]        best_q;
	logic                    scan_done;

	logic                    frozen;
	okc_sums_t               new_sums;
	logic [COUNT_BITS-1:0]   new_cnt;

	logic [2:0][DVD_W-1:0]      dvd_q;
	logic [2:0][COUNT_BITS-1:0] rem_q;
	logic [2:0][MEAN_W-1:0]     quo_q;
	logic [COUNT_BITS-1:0]      divisor_q;
	logic [DCNT_W-1:0]          div_cnt_q;

	logic [IDX_W-1:0]        res_label_q;
	okc_means_t              res_means_q;

	logic                    in_fire, seed_fire, pixel_fire;
	logic                    emit_ok, emit_fire;
	logic                    out_valid_q;

	assign cfg_ready  = 1'b1;
	assign in_fire    = in_valid && !in_stall;
	assign seed_fire  = in_fire && (opcode == OP_SEED);
	assign pixel_fire = in_fire && (opcode == OP_PIXEL);
	assign emit_ok    = !out_valid_q || !out_stall;
	assign out_valid  = out_valid_q;

	// clamp the cluster count to 1 .. MAX_CLUSTERS
	always_comb begin
		if (ncl_q == '0)
			act_last = '0;
		else if (ncl_q > NCL_W'(MAX_CLUSTERS))
			act_last = NCL_W'(MAX_CLUSTERS - 1);
		else
			act_last = ncl_q - NCL_W'(1);
	end

	assign issue_active = (state_q == S_SCAN) && (issue_q <= act_last);
	assign scan_done    = v_s2 && (idx_s2 == act_last[IDX_W-1:0]);
	assign frozen       = (cnt_rd_s1 == '1);
	assign new_cnt      = cnt_rd_s1 + COUNT_BITS'(1);

	always_comb begin
		logic [SUM_W:0] t;
		for (int c = 0; c < 3; c++) begin
			t = {1'b0, sums_rd_s1[c]} + (SUM_W+1)'(pix_q[c]);
			new_sums[c] = t[SUM_W] ? '1 : t[SUM_W-1:0];
		end
	end

	always_comb begin
		dist_sum = '0;
		for (int c = 0; c < 3; c++)
			dist_sum = dist_sum + DIST_W'(sq_s2[c]);
	end

	// next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (seed_fire)
					state_nxt = S_EMIT;
				else if (pixel_fire)
					state_nxt = S_SCAN;
			end
			S_SCAN: if (scan_done) state_nxt = S_RD;
			S_RD:   state_nxt = S_UPD;
			S_UPD:  state_nxt = frozen ? S_EMIT : S_DIV;
			S_DIV:  if (div_cnt_q == DCNT_W'(DIV_STEPS - 1)) state_nxt = S_WR;
			S_WR:   state_nxt = S_EMIT;
			S_EMIT: if (emit_ok) state_nxt = S_IDLE;
			default: state_nxt = S_IDLE;
		endcase
	end

	// state outputs
	always_comb begin
		in_stall  = (state_q != S_IDLE);
		emit_fire = (state_q == S_EMIT) && emit_ok;
		rd_en     = issue_active || (state_q == S_RD);
		rd_addr   = (state_q == S_RD) ? best_q : issue_q[IDX_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			ncl_q       <= NCL_W'(NCL_RESET);
			out_valid_q <= 1'b0;
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			issue_q     <= '0;
			div_cnt_q   <= '0;
		end else begin
			state_q <= state_nxt;
			if (cfg_valid && cfg_ready)
				ncl_q <= cfg_data;
			if (emit_fire)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
			v_s1 <= issue_active;
			v_s2 <= v_s1;
			if (pixel_fire)
				issue_q <= '0;
			else if (issue_active)
				issue_q <= issue_q + NCL_W'(1);
			if (state_q == S_DIV)
				div_cnt_q <= div_cnt_q + DCNT_W'(1);
			else
				div_cnt_q <= '0;
		end
	end

	// cluster memories
	always_ff @(posedge clk) begin
		if (rd_en) begin
			means_rd_s1 <= means_mem[rd_addr];
			sums_rd_s1  <= sums_mem[rd_addr];
			cnt_rd_s1   <= cnt_mem[rd_addr];
		end
		if (seed_fire) begin
			means_mem[cluster_index] <= {blue, 8'h00, green, 8'h00, red, 8'h00};
			sums_mem[cluster_index]  <= {SUM_W'(blue), SUM_W'(green), SUM_W'(red)};
			cnt_mem[cluster_index]   <= COUNT_BITS'(1);
		end else if (state_q == S_UPD && !frozen) begin
			sums_mem[best_q] <= new_sums;
			cnt_mem[best_q]  <= new_cnt;
		end else if (state_q == S_WR) begin
			means_mem[best_q] <= quo_q;
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		logic [MEAN_W-1:0]   p, d;
		logic [COUNT_BITS:0] t;
		if (in_fire) begin
			pix_q <= {blue, green, red};
			eop_q <= end_of_pass;
		end
		idx_s1 <= issue_q[IDX_W-1:0];
		idx_s2 <= idx_s1;
		for (int c = 0; c < 3; c++) begin
			p = {pix_q[c], 8'h00};
			d = (p >= means_rd_s1[c]) ? p - means_rd_s1[c] : means_rd_s1[c] - p;
			sq_s2[c] <= d * d;
		end
		if (v_s2 && (idx_s2 == '0 || dist_sum < best_d_q)) begin
			best_d_q <= dist_sum;
			best_q   <= idx_s2;
		end
		if (state_q == S_UPD) begin
			divisor_q <= new_cnt;
			for (int c = 0; c < 3; c++) begin
				dvd_q[c] <= {new_sums[c], 8'h00};
				rem_q[c] <= '0;
			end
		end else if (state_q == S_DIV) begin
			// restoring division, one quotient bit per cycle
			for (int c = 0; c < 3; c++) begin
				t = {rem_q[c], dvd_q[c][DVD_W-1]};
				if (t >= {1'b0, divisor_q}) begin
					rem_q[c] <= COUNT_BITS'(t - {1'b0, divisor_q});
					quo_q[c] <= {quo_q[c][MEAN_W-2:0], 1'b1};
				end else begin
					rem_q[c] <= t[COUNT_BITS-1:0];
					quo_q[c] <= {quo_q[c][MEAN_W-2:0], 1'b0};
				end
				dvd_q[c] <= {dvd_q[c][DVD_W-2:0], 1'b0};
			end
		end
		if (seed_fire) begin
			res_label_q <= cluster_index;
			res_means_q <= {blue, 8'h00, green, 8'h00, red, 8'h00};
		end else if (state_q == S_UPD && frozen) begin
			res_label_q <= best_q;
			res_means_q <= means_rd_s1;
		end else if (state_q == S_WR) begin
			res_label_q <= best_q;
			res_means_q <= quo_q;
		end
		if (emit_fire) begin
			label      <= res_label_q;
			mean_red   <= res_means_q[0];
			mean_green <= res_means_q[1];
			mean_blue  <= res_means_q[2];
			pass_done  <= eop_q;
		end
	end

`ifndef SYNTHESIS
	a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |=> state_q != S_IDLE)
		else $error("accepted beat did not start work");
	a_best_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_RD |-> {1'b0, best_q} <= act_last)
		else $error("chosen cluster outside active range");
	a_div_len: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_WR |-> $past(state_q) == S_DIV)
		else $error("mean write without finished divide");
	a_no_scan_reissue: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_RD |-> !issue_active && !v_s1)
		else $error("scan pipeline busy at update read");
`endif

endmodule
